// ===== rtl/scrpd_pkg.sv =====
package scrpd_pkg;

  // Frame geometry limits and line store size.
  localparam int MAX_WIDTH     = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MAX_LINES_DEF = 8;

  localparam logic [7:0]  RESET_THRESHOLD = 8'd200;
  localparam logic [12:0] RESET_MAX_LIMIT = 13'd4097;
  localparam logic [12:0] LEN_MAX         = 13'd8191;

  localparam int COORD_W = 12;
  localparam int LEN_W   = 13;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 3;

  // Operation codes of an input beat.
  localparam logic OP_PIXEL     = 1'b0;
  localparam logic OP_FRAME_END = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIGHT_THRESHOLD = 3'd0,
    CFG_MIN_LINE_LENGTH  = 3'd1,
    CFG_MAX_LINE_LENGTH  = 3'd2,
    CFG_MIN_TRACK_WIDTH  = 3'd3,
    CFG_MAX_TRACK_WIDTH  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] row_index;
    logic [7:0]         gray_value;
    logic               row_end;
  } in_beat_t;

  typedef struct packed {
    logic               pair_found;
    logic [3:0]         first_index;
    logic [3:0]         second_index;
    logic [COORD_W-1:0] start_distance;
    logic [COORD_W-1:0] first_row;
    logic [COORD_W-1:0] first_start_x;
    logic [COORD_W-1:0] first_end_x;
    logic [COORD_W-1:0] second_row;
    logic [COORD_W-1:0] second_start_x;
    logic [COORD_W-1:0] second_end_x;
    logic               lines_dropped;
    logic               last_of_frame;
  } out_beat_t;

  // One stored run.
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] ex;
    logic [LEN_W-1:0]   len;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  // Controller to datapath.
  typedef struct packed {
    logic pix_accept;
    logic frame_accept;
    logic next_row;
    logic next_col;
    logic push_pend;
    logic load_pend;
    logic push_final;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic row_done;
    logic col_done;
    logic match;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/scrpd_ram.sv =====
module scrpd_ram #(
  parameter int WIDTH = scrpd_pkg::LINE_W,
  parameter int DEPTH = scrpd_pkg::MAX_LINES_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/scrpd_ctrl.sv =====
module scrpd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_ready,
  input  scrpd_pkg::sts_t  sts,
  output scrpd_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_PIXEL,
    ST_READ,
    ST_CHECK,
    ST_FINAL
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_PIXEL: begin
        if (in_valid && in_ready_r) begin
          if (in_op == scrpd_pkg::OP_FRAME_END) begin
            cmd.frame_accept = 1'b1;
            state_nxt        = ST_READ;
          end else begin
            cmd.pix_accept = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (sts.row_done) begin
          state_nxt = ST_FINAL;
        end else if (sts.col_done) begin
          cmd.next_row = 1'b1;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.match) begin
          cmd.next_col = 1'b1;
          state_nxt    = ST_READ;
        end else if (!sts.pend_valid || sts.out_free) begin
          cmd.push_pend = sts.pend_valid;
          cmd.load_pend = 1'b1;
          cmd.next_col  = 1'b1;
          state_nxt     = ST_READ;
        end
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.push_final = 1'b1;
          state_nxt      = ST_PIXEL;
        end
      end
      default: begin
        state_nxt = ST_PIXEL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_PIXEL;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_PIXEL);
    end
  end

`ifndef SYNTHESIS
  // A frame end stops the input until the pair walk is over.
  a_frame_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.frame_accept |=> !in_ready)
    else $error("input still ready after frame end beat");
`endif

endmodule

// ===== rtl/scrpd_dp.sv =====
module scrpd_dp #(
  parameter int MAX_LINES = scrpd_pkg::MAX_LINES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [scrpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scrpd_pkg::CFG_W-1:0]         cfg_data,
  input  scrpd_pkg::in_beat_t                 in_data,
  input  scrpd_pkg::cmd_t                     cmd,
  output scrpd_pkg::sts_t                     sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output scrpd_pkg::out_beat_t                out_data
);

  localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CNT_W = $clog2(MAX_LINES + 1);
  localparam int CW    = scrpd_pkg::COORD_W;
  localparam int LW    = scrpd_pkg::LEN_W;

  // Configuration registers.
  logic [7:0]    thr_r;
  logic [LW-1:0] min_len_r, max_len_r, min_tw_r, max_tw_r;

  // Run tracking.
  logic [CW-1:0]    col_r;
  logic [LW-1:0]    streak_len_r;
  logic [CW-1:0]    streak_start_r;
  logic [CNT_W-1:0] count_r;
  logic             ovf_r;

  // Pair walk.
  logic [CNT_W-1:0] walk_cnt_r;
  logic             drop_r;
  logic [CNT_W-1:0] i_r, j_r;
  scrpd_pkg::out_beat_t pend_r;
  logic                 pend_valid_r;
  logic                 out_valid_r;
  scrpd_pkg::out_beat_t out_data_r;

  logic                 bright, close_dark, close_end, line_close, has_room, store_we;
  logic [LW-1:0]        len_grow;
  logic [CW-1:0]        start_run;
  scrpd_pkg::line_t     new_line, line_a, line_b;
  logic [scrpd_pkg::LINE_W-1:0] rdata_a, rdata_b;
  logic [CW-1:0]        sx_gap;
  logic                 match, out_free;
  scrpd_pkg::out_beat_t pair_beat, final_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= scrpd_pkg::RESET_THRESHOLD;
      min_len_r <= '0;
      max_len_r <= scrpd_pkg::RESET_MAX_LIMIT;
      min_tw_r  <= '0;
      max_tw_r  <= scrpd_pkg::RESET_MAX_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scrpd_pkg::CFG_BRIGHT_THRESHOLD: thr_r     <= cfg_data[7:0];
        scrpd_pkg::CFG_MIN_LINE_LENGTH:  min_len_r <= cfg_data;
        scrpd_pkg::CFG_MAX_LINE_LENGTH:  max_len_r <= cfg_data;
        scrpd_pkg::CFG_MIN_TRACK_WIDTH:  min_tw_r  <= cfg_data;
        scrpd_pkg::CFG_MAX_TRACK_WIDTH:  max_tw_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    bright = (in_data.gray_value > thr_r) &&
             ({1'b0, in_data.row_index} < (CW + 1)'(scrpd_pkg::MAX_HEIGHT));
    len_grow   = (streak_len_r < scrpd_pkg::LEN_MAX) ? streak_len_r + LW'(1) : streak_len_r;
    start_run  = (streak_len_r == '0) ? col_r : streak_start_r;
    close_dark = !bright && (streak_len_r != '0);
    close_end  = bright && in_data.row_end;
    line_close = close_dark || close_end;
    has_room   = count_r < CNT_W'(MAX_LINES);
    store_we   = cmd.pix_accept && line_close && has_room;
    new_line.row = in_data.row_index;
    if (close_dark) begin
      new_line.sx  = streak_start_r;
      new_line.ex  = col_r - CW'(1);
      new_line.len = streak_len_r;
    end else begin
      new_line.sx  = start_run;
      new_line.ex  = col_r;
      new_line.len = len_grow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r          <= '0;
      streak_len_r   <= '0;
      streak_start_r <= '0;
      count_r        <= '0;
      ovf_r          <= 1'b0;
    end else if (cmd.frame_accept) begin
      col_r          <= '0;
      streak_len_r   <= '0;
      streak_start_r <= '0;
      count_r        <= '0;
      ovf_r          <= 1'b0;
    end else if (cmd.pix_accept) begin
      streak_len_r <= (bright && !in_data.row_end) ? len_grow : '0;
      if (bright) begin
        streak_start_r <= start_run;
      end
      if (in_data.row_end) begin
        col_r <= '0;
      end else if (col_r < CW'(scrpd_pkg::MAX_WIDTH - 1)) begin
        col_r <= col_r + CW'(1);
      end
      if (line_close) begin
        if (has_room) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  // Two copies of the line store so that both lines of a pair read at once.
  scrpd_ram #(.WIDTH(scrpd_pkg::LINE_W), .DEPTH(MAX_LINES)) u_store_a (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (new_line),
    .raddr (i_r[IDX_W-1:0]),
    .rdata (rdata_a)
  );

  scrpd_ram #(.WIDTH(scrpd_pkg::LINE_W), .DEPTH(MAX_LINES)) u_store_b (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (new_line),
    .raddr (j_r[IDX_W-1:0]),
    .rdata (rdata_b)
  );

  always_comb begin
    line_a = scrpd_pkg::line_t'(rdata_a);
    line_b = scrpd_pkg::line_t'(rdata_b);
    sx_gap = (line_a.sx >= line_b.sx) ? line_a.sx - line_b.sx : line_b.sx - line_a.sx;
    match  = (line_a.len > min_len_r) && (line_a.len < max_len_r) &&
             (line_b.len > min_len_r) && (line_b.len < max_len_r) &&
             ({1'b0, sx_gap} > min_tw_r) && ({1'b0, sx_gap} < max_tw_r);

    pair_beat                = '0;
    pair_beat.pair_found     = 1'b1;
    pair_beat.first_index    = 4'(i_r);
    pair_beat.second_index   = 4'(j_r);
    pair_beat.start_distance = sx_gap;
    pair_beat.first_row      = line_a.row;
    pair_beat.first_start_x  = line_a.sx;
    pair_beat.first_end_x    = line_a.ex;
    pair_beat.second_row     = line_b.row;
    pair_beat.second_start_x = line_b.sx;
    pair_beat.second_end_x   = line_b.ex;
    pair_beat.lines_dropped  = drop_r;

    if (pend_valid_r) begin
      final_beat = pend_r;
    end else begin
      final_beat               = '0;
      final_beat.lines_dropped = drop_r;
    end
    final_beat.last_of_frame = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_cnt_r <= '0;
      drop_r     <= 1'b0;
      i_r        <= '0;
      j_r        <= CNT_W'(1);
    end else if (cmd.frame_accept) begin
      walk_cnt_r <= count_r;
      drop_r     <= ovf_r;
      i_r        <= '0;
      j_r        <= CNT_W'(1);
    end else if (cmd.next_row) begin
      i_r <= i_r + CNT_W'(1);
      j_r <= i_r + CNT_W'(2);
    end else if (cmd.next_col) begin
      j_r <= j_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pend) begin
      pend_r <= pair_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.load_pend) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.push_final) begin
      pend_valid_r <= 1'b0;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_pend) begin
      out_valid_r <= 1'b1;
    end else if (cmd.push_final) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_pend) begin
      out_data_r <= pend_r;
    end else if (cmd.push_final) begin
      out_data_r <= final_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.row_done   = (i_r + CNT_W'(1)) >= walk_cnt_r;
  assign sts.col_done   = j_r >= walk_cnt_r;
  assign sts.match      = match;
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;

`ifndef SYNTHESIS
  a_push_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_pend || cmd.push_final) |-> out_free)
    else $error("result pushed over an untaken beat");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_LINES))
    else $error("line count beyond store depth");

  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    j_r > i_r)
    else $error("pair walk index order broken");
`endif

endmodule

// ===== rtl/scanline_run_pair_detector_top.sv =====
// Pixel beats: one per cycle, no result; a run closes into the line store in the same cycle.
// Frame end beat: the pair walk visits each pair of stored lines, first a store read,
//   then a compare, then results leave through a one-beat output register; an output
//   stall holds the walk.
// Input stays blocked during the walk; each found pair waits until the next match or walk end.
// Reset: synchronous, active low; clears run state, line count, flags and config defaults.
module scanline_run_pair_detector_top #(
  parameter int MAX_LINES = scrpd_pkg::MAX_LINES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [scrpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scrpd_pkg::CFG_W-1:0]     cfg_data,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  scrpd_pkg::in_beat_t             in_data,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output scrpd_pkg::out_beat_t            out_data
);

  // Command and status bundles between the sequencer and the datapath.
  scrpd_pkg::cmd_t cmd;
  scrpd_pkg::sts_t sts;

  // Sequencer: accepts pixel beats, then on frame end walks every pair i<j,
  // holds one found pair back so the final one can carry last_of_frame.
  scrpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: config registers, run tracking, line store, pair compare,
  // pending pair and the output register.
  scrpd_dp #(.MAX_LINES(MAX_LINES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINES         = scrpd_pkg::MAX_LINES_DEF;
  localparam int SETTLE_CYCLES = 16;       // idle margin after the last result or pixel
  localparam int REPORT_LIMIT  = 10;       // mismatches printed in full
  localparam int TIMEOUT_NS    = 4000000;  // several times the slowest run
  localparam int LONG_ROW_LIT  = 24;       // a lit run well past the random rows

  // Index past the end of the register list; writes there must be ignored.
  localparam logic [scrpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [scrpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [scrpd_pkg::CFG_W-1:0]     cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  scrpd_pkg::in_beat_t             in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  scrpd_pkg::out_beat_t            out_data;

  scanline_run_pair_detector_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Line tracker: our own copy of the registers and the run/line state.
  // ---------------------------------------------------------------------------
  logic [7:0]                    thr_cfg;
  logic [scrpd_pkg::LEN_W-1:0]   min_len_cfg;
  logic [scrpd_pkg::LEN_W-1:0]   max_len_cfg;
  logic [scrpd_pkg::LEN_W-1:0]   min_gap_cfg;
  logic [scrpd_pkg::LEN_W-1:0]   max_gap_cfg;

  logic [scrpd_pkg::COORD_W-1:0] col_pos;
  logic [scrpd_pkg::LEN_W-1:0]   run_len;
  logic [scrpd_pkg::COORD_W-1:0] run_sx;
  scrpd_pkg::line_t              lines [LINES];
  int                            n_lines;
  logic                          lines_lost;

  scrpd_pkg::in_beat_t           scan_beats [$];    // beats waiting to be driven
  scrpd_pkg::out_beat_t          pair_reports [$];  // results still owed by the block

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  beats_driven  = 0;
  int  beats_queued  = 0;
  int  beats_sent    = 0;
  int  frames_sent   = 0;
  int  results_seen  = 0;
  int  pairs_seen    = 0;
  int  settings_used = 0;
  int  mismatches    = 0;
  int  fail_count    = 0;

  function automatic void clear_frame_state();
    col_pos    = '0;
    run_len    = '0;
    run_sx     = '0;
    n_lines    = 0;
    lines_lost = 1'b0;
  endfunction

  function automatic void keep_line(logic [scrpd_pkg::COORD_W-1:0] row,
                                    logic [scrpd_pkg::COORD_W-1:0] sx,
                                    logic [scrpd_pkg::COORD_W-1:0] ex,
                                    logic [scrpd_pkg::LEN_W-1:0] len);
    if (n_lines < LINES) begin
      lines[n_lines].row = row;
      lines[n_lines].sx  = sx;
      lines[n_lines].ex  = ex;
      lines[n_lines].len = len;
      n_lines++;
    end else begin
      lines_lost = 1'b1;
    end
  endfunction

  function automatic bit len_fits(logic [scrpd_pkg::LEN_W-1:0] len);
    return (len > min_len_cfg) && (len < max_len_cfg);
  endfunction

  // Advance the run tracker by one pixel.
  function automatic void scan_pixel(scrpd_pkg::in_beat_t b);
    logic [scrpd_pkg::COORD_W-1:0] x;
    bit                            lit;
    x   = col_pos;
    lit = (b.gray_value > thr_cfg) && (int'(b.row_index) < scrpd_pkg::MAX_HEIGHT);
    if (lit) begin
      if (run_len == '0) run_sx = x;
      if (run_len < scrpd_pkg::LEN_MAX) run_len++;
    end else if (run_len != '0) begin
      // A dark pixel closes the run one column back.
      keep_line(b.row_index, run_sx, x - 12'd1, run_len);
      run_len = '0;
    end
    if (b.row_end) begin
      // A run still open on the last pixel closes at this column.
      if (run_len != '0) keep_line(b.row_index, run_sx, x, run_len);
      run_len = '0;
      col_pos = '0;
    end else if (int'(col_pos) < scrpd_pkg::MAX_WIDTH - 1) begin
      col_pos++;
    end
  endfunction

  // Walk all stored line pairs in i-then-j order and queue the frame's results.
  function automatic void pair_lines();
    scrpd_pkg::out_beat_t          r;
    logic [scrpd_pkg::COORD_W-1:0] d;
    int                            i;
    int                            j;
    int                            found;
    found = 0;
    for (i = 0; i < n_lines; i++) begin
      if (!len_fits(lines[i].len)) continue;
      for (j = i + 1; j < n_lines; j++) begin
        if (!len_fits(lines[j].len)) continue;
        d = (lines[i].sx > lines[j].sx) ? lines[i].sx - lines[j].sx
                                        : lines[j].sx - lines[i].sx;
        if (!({1'b0, d} > min_gap_cfg && {1'b0, d} < max_gap_cfg)) continue;
        r                = '0;
        r.pair_found     = 1'b1;
        r.first_index    = 4'(i);
        r.second_index   = 4'(j);
        r.start_distance = d;
        r.first_row      = lines[i].row;
        r.first_start_x  = lines[i].sx;
        r.first_end_x    = lines[i].ex;
        r.second_row     = lines[j].row;
        r.second_start_x = lines[j].sx;
        r.second_end_x   = lines[j].ex;
        r.lines_dropped  = lines_lost;
        pair_reports     = {pair_reports, r};
        found++;
      end
    end
    if (found == 0) begin
      // No pair found: a lone closing result with only the drop flag.
      r               = '0;
      r.lines_dropped = lines_lost;
      r.last_of_frame = 1'b1;
      pair_reports    = {pair_reports, r};
    end else begin
      r               = pair_reports.pop_back();
      r.last_of_frame = 1'b1;
      pair_reports    = {pair_reports, r};
    end
    clear_frame_state();
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Gray levels are picked against the current threshold.
  // ---------------------------------------------------------------------------
  function automatic void queue_beat(logic op, logic [scrpd_pkg::COORD_W-1:0] row,
                                     logic [7:0] gray, logic rend);
    scrpd_pkg::in_beat_t b;
    b.op         = op;
    b.row_index  = row;
    b.gray_value = gray;
    b.row_end    = rend;
    scan_beats   = {scan_beats, b};
    beats_queued++;
  endfunction

  function automatic logic [7:0] lit_gray();
    if (thr_cfg == 8'hFF) return 8'hFF;
    return 8'($urandom_range(255, int'(thr_cfg) + 1));
  endfunction

  function automatic logic [7:0] dark_gray();
    return 8'($urandom_range(int'(thr_cfg), 0));
  endfunction

  function automatic void queue_frame_end();
    // Only op matters on a frame end; scramble the rest.
    queue_beat(scrpd_pkg::OP_FRAME_END, 12'($urandom), 8'($urandom),
               1'($urandom_range(1)));
  endfunction

  // Mostly well-formed rows with random runs; some stray pixels, some frames cut mid-row.
  function automatic void queue_random_frame();
    int                            rows;
    int                            w;
    int                            r;
    int                            k;
    bit                            lit;
    bit                            cut;
    logic [scrpd_pkg::COORD_W-1:0] row;
    rows = $urandom_range(4, 1);
    if ($urandom_range(9) == 0) rows = $urandom_range(8, 5);
    cut  = ($urandom_range(9) == 0);
    row  = 12'($urandom);
    for (r = 0; r < rows; r++) begin
      w   = $urandom_range(16, 3);
      lit = 1'($urandom_range(1));
      if (cut && r == rows - 1) w = $urandom_range(w, 1) - 1;
      for (k = 0; k < w; k++) begin
        if ($urandom_range(99) < 20) lit = !lit;
        if ($urandom_range(99) < 6)
          queue_beat(scrpd_pkg::OP_PIXEL, 12'($urandom), 8'($urandom),
                     1'($urandom_range(1)));
        else
          queue_beat(scrpd_pkg::OP_PIXEL, row, lit ? lit_gray() : dark_gray(),
                     (k == w - 1) && !(cut && r == rows - 1));
      end
      row = row + 12'($urandom_range(5, 1));
    end
    queue_frame_end();
  endfunction

  // Short hand-picked sequence under the reset register values (threshold 200).
  function automatic void queue_directed();
    int k;
    // Row 0: runs closed by a dark pixel, by a threshold-equal pixel, and by row end.
    queue_beat(scrpd_pkg::OP_PIXEL, 12'd0, 8'd255, 1'b0);
    queue_beat(scrpd_pkg::OP_PIXEL, 12'd0, 8'd255, 1'b0);
    queue_beat(scrpd_pkg::OP_PIXEL, 12'd0, 8'd0,   1'b0);
    queue_beat(scrpd_pkg::OP_PIXEL, 12'd0, 8'd201, 1'b0);
    queue_beat(scrpd_pkg::OP_PIXEL, 12'd0, 8'd200, 1'b0);
    queue_beat(scrpd_pkg::OP_PIXEL, 12'd0, 8'd255, 1'b1);
    // Top row index, run open at row end.
    queue_beat(scrpd_pkg::OP_PIXEL, 12'hFFF, 8'd0,   1'b0);
    queue_beat(scrpd_pkg::OP_PIXEL, 12'hFFF, 8'd255, 1'b0);
    queue_beat(scrpd_pkg::OP_PIXEL, 12'hFFF, 8'd255, 1'b1);
    queue_frame_end();
    // Run left open when the frame ends: discarded, empty result.
    queue_beat(scrpd_pkg::OP_PIXEL, 12'd7, 8'd255, 1'b0);
    queue_beat(scrpd_pkg::OP_PIXEL, 12'd7, 8'd230, 1'b0);
    queue_frame_end();
    // Nine one-pixel rows: the store fills and the last line is dropped.
    for (k = 0; k < LINES + 1; k++)
      queue_beat(scrpd_pkg::OP_PIXEL, 12'(k + 100), 8'd250, 1'b1);
    queue_frame_end();
    // Frame end with nothing stored.
    queue_frame_end();
  endfunction

  // One row with a long lit run closed by a dark last pixel, then a short run
  // closed the same way on the next row.
  function automatic void queue_long_row();
    int k;
    for (k = 0; k < 5; k++) queue_beat(scrpd_pkg::OP_PIXEL, 12'd2048, dark_gray(), 1'b0);
    for (k = 0; k < LONG_ROW_LIT; k++)
      queue_beat(scrpd_pkg::OP_PIXEL, 12'd2048, lit_gray(), 1'b0);
    queue_beat(scrpd_pkg::OP_PIXEL, 12'd2048, dark_gray(), 1'b1);
    for (k = 0; k < 3; k++) queue_beat(scrpd_pkg::OP_PIXEL, 12'd2049, dark_gray(), 1'b0);
    for (k = 0; k < 4; k++) queue_beat(scrpd_pkg::OP_PIXEL, 12'd2049, lit_gray(), 1'b0);
    queue_beat(scrpd_pkg::OP_PIXEL, 12'd2049, dark_gray(), 1'b1);
    queue_frame_end();
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes: only while the block is idle; mirror them into the tracker.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [scrpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scrpd_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      scrpd_pkg::CFG_BRIGHT_THRESHOLD: thr_cfg     = val[7:0];
      scrpd_pkg::CFG_MIN_LINE_LENGTH:  min_len_cfg = val;
      scrpd_pkg::CFG_MAX_LINE_LENGTH:  max_len_cfg = val;
      scrpd_pkg::CFG_MIN_TRACK_WIDTH:  min_gap_cfg = val;
      scrpd_pkg::CFG_MAX_TRACK_WIDTH:  max_gap_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(input logic [scrpd_pkg::CFG_W-1:0] thr,
                            input logic [scrpd_pkg::CFG_W-1:0] len_lo,
                            input logic [scrpd_pkg::CFG_W-1:0] len_hi,
                            input logic [scrpd_pkg::CFG_W-1:0] gap_lo,
                            input logic [scrpd_pkg::CFG_W-1:0] gap_hi);
    write_reg(scrpd_pkg::CFG_BRIGHT_THRESHOLD, thr);
    write_reg(scrpd_pkg::CFG_MIN_LINE_LENGTH, len_lo);
    write_reg(scrpd_pkg::CFG_MAX_LINE_LENGTH, len_hi);
    write_reg(scrpd_pkg::CFG_MIN_TRACK_WIDTH, gap_lo);
    write_reg(scrpd_pkg::CFG_MAX_TRACK_WIDTH, gap_hi);
    settings_used++;
  endtask

  // Hold until every queued beat is taken and every owed result has arrived,
  // then let the block settle. Sampled at the rising edge so queue pops at the
  // falling edge cannot race the check.
  task automatic wait_idle();
    do @(posedge clk);
    while (scan_beats.size() != 0 || in_valid || pair_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: present the next beat at the falling edge, with random gaps between
  // beats. Valid is never dropped before its beat is taken; the beat on the bus
  // is taken once the accepted count catches up with the driven count.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : scan_drive
    logic                nxt_valid;
    scrpd_pkg::in_beat_t nxt_beat;
    nxt_valid = in_valid;
    nxt_beat  = in_data;
    if (in_valid && beats_sent == beats_driven) begin
      nxt_valid = 1'b0;
    end
    if (!nxt_valid && scan_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      nxt_beat  = scan_beats.pop_front();
      nxt_valid = 1'b1;
      beats_driven++;
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_beat;
  end

  // Receiver: stall at random.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Accepted input beat: advance the tracker, which queues results on frame end.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      beats_sent++;
      if (in_data.op == scrpd_pkg::OP_FRAME_END) begin
        frames_sent++;
        pair_lines();
      end else begin
        scan_pixel(in_data);
      end
    end
  end

  function automatic void show_beat(string tag, scrpd_pkg::out_beat_t b);
    $display("  %s: p=%0b idx=%0d/%0d d=%0d a=(%0d,%0d,%0d) b=(%0d,%0d,%0d) drop=%0b last=%0b",
             tag, b.pair_found, b.first_index, b.second_index, b.start_distance,
             b.first_row, b.first_start_x, b.first_end_x,
             b.second_row, b.second_start_x, b.second_end_x,
             b.lines_dropped, b.last_of_frame);
  endfunction

  // Accepted result beat: compare field by field with the oldest owed result.
  always @(posedge clk) begin : result_check
    scrpd_pkg::out_beat_t want;
    bit                   bad;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pair_reports.size() == 0) begin
        fail_count++;
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("ERROR: result beat %0d arrived with nothing owed", results_seen);
          show_beat("got ", out_data);
        end
      end else begin
        want = pair_reports.pop_front();
        if (want.pair_found) pairs_seen++;
        bad = (out_data.pair_found     !== want.pair_found)     ||
              (out_data.first_index    !== want.first_index)    ||
              (out_data.second_index   !== want.second_index)   ||
              (out_data.start_distance !== want.start_distance) ||
              (out_data.first_row      !== want.first_row)      ||
              (out_data.first_start_x  !== want.first_start_x)  ||
              (out_data.first_end_x    !== want.first_end_x)    ||
              (out_data.second_row     !== want.second_row)     ||
              (out_data.second_start_x !== want.second_start_x) ||
              (out_data.second_end_x   !== want.second_end_x)   ||
              (out_data.lines_dropped  !== want.lines_dropped)  ||
              (out_data.last_of_frame  !== want.last_of_frame);
        if (bad) begin
          fail_count++;
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("ERROR: result beat %0d differs", results_seen);
            show_beat("want", want);
            show_beat("got ", out_data);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int goal;
    // Tracker starts from the reset register values.
    thr_cfg     = scrpd_pkg::RESET_THRESHOLD;
    min_len_cfg = '0;
    max_len_cfg = scrpd_pkg::RESET_MAX_LIMIT;
    min_gap_cfg = '0;
    max_gap_cfg = scrpd_pkg::RESET_MAX_LIMIT;
    clear_frame_state();
    settings_used = 1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase 1: sender idles a third of the time, receiver two thirds.
    send_idle_pct = 33;
    recv_idle_pct = 67;
    queue_directed();
    wait_idle();
    set_limits(13'd128, 13'd1, 13'd12, 13'd0, 13'd20);
    while (beats_queued < 140) queue_random_frame();
    wait_idle();

    // Phase 2: swap the idle ratios; open the limits all the way.
    send_idle_pct = 67;
    recv_idle_pct = 33;
    set_limits(13'd0, 13'd0, 13'd4097, 13'd0, 13'd4097);
    while (beats_queued < 250) queue_random_frame();
    wait_idle();
    // Closed-off extremes; the threshold write carries junk above bit 7.
    set_limits(13'h1FFF, 13'd4096, 13'd0, 13'd4096, 13'd0);
    queue_random_frame();
    queue_random_frame();
    wait_idle();
    // A write past the register list must leave everything alone.
    set_limits(13'd90, 13'd2, 13'd9, 13'd1, 13'd12);
    write_reg(CFG_SPARE_IDX, 13'd0);
    while (beats_queued < 290) queue_random_frame();
    wait_idle();

    // Phase 3: no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limits(13'd100, 13'd0, 13'd4097, 13'd0, 13'd4097);
    queue_long_row();
    wait_idle();
    set_limits(13'd160, 13'd0, 13'd10, 13'd2, 13'd15);
    goal = beats_queued + 35;
    while (beats_queued < goal) queue_random_frame();
    // Queue no more frames until the block has nothing left to report.
    wait_idle();
    goal = beats_queued + 35;
    while (beats_queued < goal) queue_random_frame();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Anything still owed counts as a failure.
    if (pair_reports.size() != 0) begin
      $display("ERROR: %0d results never arrived", pair_reports.size());
      fail_count += pair_reports.size();
    end

    $display("Run covered %0d input beats in %0d frames under %0d register settings,",
             beats_sent, frames_sent, settings_used);
    $display("checking %0d result beats (%0d line pairs), %0d mismatching",
             results_seen, pairs_seen, mismatches);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: stop a hung run.
  initial begin
    #TIMEOUT_NS;
    $display("ERROR: timeout, %0d results still owed", pair_reports.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
